@@ rtl/core/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg - shared definitions for the associative key/value table
// Table geometry, command codes and the structs that pass between the cells.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Table geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  active;
    logic                  match;
    logic [IDX_BITS-1:0]   match_idx;
    logic [VALUE_BITS-1:0] match_val;
    logic                  free;
    logic [IDX_BITS-1:0]   free_idx;
  } probe_t;

  // Update broadcast to all cells at the end of a search
  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   idx;
    logic                  load_key;
    logic                  load_value;
    logic                  set_valid;
    logic                  clear_valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } upd_t;

endpackage

@@ rtl/core/kvt_if.sv @@
// ----------------------------------------------------------------------------
// kvt_if - valid/ready channels of the key/value table
// Command channel (command, key, value) and response channel.
// ----------------------------------------------------------------------------
interface kvt_cmd_if;
  import kvt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface kvt_rsp_if;
  import kvt_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] read_value;
  logic               table_full;
  logic [SLOT_W-1:0]  slot;

  modport source (output valid, hit, read_value, table_full, slot, input ready);
  modport sink   (input valid, hit, read_value, table_full, slot, output ready);
endinterface

@@ rtl/core/kvt_cell.sv @@
// ----------------------------------------------------------------------------
// kvt_cell - one table entry
// Holds key, value and valid mark. Compares the search key against its entry,
// merges the outcome into the passing token and registers it for the next cell.
// ----------------------------------------------------------------------------
module kvt_cell
  import kvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_BITS-1:0]   cell_index,
  input  logic                  advance,
  input  logic [KEY_BITS-1:0]   search_key,
  input  probe_t                probe_in,
  output probe_t                probe_out,
  input  upd_t                  upd
);

  logic [KEY_BITS-1:0]   entry_key;
  logic [VALUE_BITS-1:0] entry_value;
  logic                  entry_valid;
  probe_t                probe_next;
  logic                  upd_hit;

  assign upd_hit = upd.en && (upd.idx == cell_index);

  // Token merge: first valid match and first free entry win
  always_comb begin
    probe_next = probe_in;
    if (probe_in.active) begin
      if (!probe_in.match && entry_valid && (entry_key == search_key)) begin
        probe_next.match     = 1'b1;
        probe_next.match_idx = cell_index;
        probe_next.match_val = entry_value;
      end
      if (!probe_in.free && !entry_valid) begin
        probe_next.free     = 1'b1;
        probe_next.free_idx = cell_index;
      end
    end
  end

  // Token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else if (advance) begin
      probe_out <= probe_next;
    end
  end

  // Valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (upd_hit) begin
      if (upd.set_valid) begin
        entry_valid <= 1'b1;
      end else if (upd.clear_valid) begin
        entry_valid <= 1'b0;
      end
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk) begin
    if (upd_hit && upd.load_key) begin
      entry_key <= upd.key;
    end
    if (upd_hit && upd.load_value) begin
      entry_value <= upd.value;
    end
  end

endmodule

@@ rtl/core/associative_key_value_table_core.sv @@
// ----------------------------------------------------------------------------
// associative_key_value_table_core - fully associative key/value table
// Each command word (set, erase, lookup, or the unused code) returns one response
// word with hit, the old value on a hit, a full flag for a dropped set, and the
// entry index. Between one acceptance and the next, after capture, a search
// token walks the row of entry cells one cell per cycle, and the update plus
// response register load happen in the cycle it leaves the last cell. One
// command is in flight at a time; the response register lets the next command
// in while a response waits. The valid marks clear on reset, so the table is
// usable at once.
// ----------------------------------------------------------------------------
module associative_key_value_table_core
  import kvt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  kvt_cmd_if.sink   cmd,
  kvt_rsp_if.source rsp
);

  logic                  busy;
  logic                  launch;
  logic [CMD_W-1:0]      cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  probe_t                head;
  probe_t                chain [ENTRIES];
  probe_t                tail;
  upd_t                  upd;
  logic                  accept;
  logic                  finish;
  logic                  advance;

  logic                  rsp_valid;
  logic                  rsp_hit;
  logic [VALUE_W-1:0]    rsp_value;
  logic                  rsp_full;
  logic [SLOT_W-1:0]     rsp_slot;

  logic                  hit_next;
  logic [VALUE_W-1:0]    value_next;
  logic                  full_next;
  logic [SLOT_W-1:0]     slot_next;

  assign cmd.ready = !busy;
  assign accept    = cmd.valid && !busy;

  assign tail    = chain[ENTRIES-1];
  assign finish  = tail.active && (!rsp_valid || rsp.ready);
  assign advance = !(tail.active && !finish);

  // Token entering the first cell
  always_comb begin
    head        = '0;
    head.active = launch;
  end

  // Command capture and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
    end else begin
      launch <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd.command;
      key_q <= KEY_BITS'(cmd.key);
      val_q <= VALUE_BITS'(cmd.value);
    end
  end

  // Row of entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_BITS'(i)),
      .advance    (advance),
      .search_key (key_q),
      .probe_in   ((i == 0) ? head : chain[(i == 0) ? 0 : i - 1]),
      .probe_out  (chain[i]),
      .upd        (upd)
    );
  end

  // Decision once the token has seen every entry
  always_comb begin
    upd        = '0;
    upd.key    = key_q;
    upd.value  = val_q;
    hit_next   = 1'b0;
    value_next = '0;
    full_next  = 1'b0;
    slot_next  = '0;
    if (cmd_q == CMD_SET || cmd_q == CMD_ERASE || cmd_q == CMD_LOOKUP) begin
      if (tail.match) begin
        hit_next   = 1'b1;
        value_next = VALUE_W'(tail.match_val);
        slot_next  = SLOT_W'(tail.match_idx);
        upd.idx    = tail.match_idx;
        unique case (cmd_q)
          CMD_SET: begin
            upd.en         = finish;
            upd.load_value = 1'b1;
          end
          CMD_ERASE: begin
            upd.en          = finish;
            upd.clear_valid = 1'b1;
          end
          default: begin
            upd.en = 1'b0;
          end
        endcase
      end else if (cmd_q == CMD_SET) begin
        if (tail.free) begin
          slot_next      = SLOT_W'(tail.free_idx);
          upd.en         = finish;
          upd.idx        = tail.free_idx;
          upd.load_key   = 1'b1;
          upd.load_value = 1'b1;
          upd.set_valid  = 1'b1;
        end else begin
          full_next = 1'b1;
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_hit   <= hit_next;
      rsp_value <= value_next;
      rsp_full  <= full_next;
      rsp_slot  <= slot_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;
  assign rsp.table_full = rsp_full;
  assign rsp.slot       = rsp_slot;

endmodule

@@ bench/kvt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_checker - scoreboard for the associative key/value table
// Watches both channels, keeps a shadow copy of the table, works out the
// response word that each accepted command word must give, and compares every
// accepted response word against the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module kvt_checker
  import kvt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  kvt_cmd_if   cmd,
  kvt_rsp_if   rsp,
  output int   fails,
  output int   pending,
  output int   replies,
  output int   hits,
  output int   fulls
);

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               table_full;
    logic [SLOT_W-1:0]  slot;
  } reply_t;

  localparam int REPORT_MAX = 10;

  // Shadow table; keys and values only matter where the live mark is set
  logic [KEY_BITS-1:0]   shadow_key [ENTRIES];
  logic [VALUE_BITS-1:0] shadow_val [ENTRIES];
  logic [ENTRIES-1:0]    shadow_live;

  reply_t replies_due [$];
  int     fail_total;
  int     reply_total;
  int     hit_total;
  int     full_total;

  // Run one command against the shadow table, return the reply it must give
  function automatic reply_t table_step(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
    reply_t r;
    int     found;
    int     spare;
    r = '0;
    found = -1;
    spare = -1;
    if (op != CMD_SET && op != CMD_ERASE && op != CMD_LOOKUP) return r;
    // scan downward so the lowest match and the lowest free entry win
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_live[i] && shadow_key[i] == KEY_BITS'(k)) found = i;
      if (!shadow_live[i]) spare = i;
    end
    if (found >= 0) begin
      r.hit        = 1'b1;
      r.read_value = VALUE_W'(shadow_val[found]);
      r.slot       = SLOT_W'(found);
      if (op == CMD_SET) shadow_val[found] = VALUE_BITS'(v);
      else if (op == CMD_ERASE) shadow_live[found] = 1'b0;
    end else if (op == CMD_SET) begin
      if (spare >= 0) begin
        shadow_key[spare]  = KEY_BITS'(k);
        shadow_val[spare]  = VALUE_BITS'(v);
        shadow_live[spare] = 1'b1;
        r.slot             = SLOT_W'(spare);
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  // Response side first: a response never belongs to a command taken the same edge
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      shadow_live = '0;
      replies_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.hit        = rsp.hit;
        got.read_value = rsp.read_value;
        got.table_full = rsp.table_full;
        got.slot       = rsp.slot;
        reply_total++;
        if (replies_due.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("%0t: response word with none outstanding:", $realtime);
            $display("  got      hit=%0b value=%08h full=%0b slot=%0d",
                     got.hit, got.read_value, got.table_full, got.slot);
          end
        end else begin
          want = replies_due.pop_front();
          if (want.hit) hit_total++;
          if (want.table_full) full_total++;
          if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_MAX) begin
              $display("%0t: response %0d mismatch", $realtime, reply_total);
              $display("  expected hit=%0b value=%08h full=%0b slot=%0d",
                       want.hit, want.read_value, want.table_full, want.slot);
              $display("  got      hit=%0b value=%08h full=%0b slot=%0d",
                       got.hit, got.read_value, got.table_full, got.slot);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready)
        replies_due.push_back(table_step(cmd.command, cmd.key, cmd.value));
    end
    fails   <= fail_total;
    pending <= replies_due.size();
    replies <= reply_total;
    hits    <= hit_total;
    fulls   <= full_total;
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the associative key/value table
// A directed opening covers the field extremes, every command, hit and miss
// on each, erased keys, the unused command code and a dropped set on a full
// table. Random phases follow, mostly on a small key pool so that entries
// collide, refill and overflow, with bursts of stalls on both channels in most phases.
// ----------------------------------------------------------------------------
module testbench;
  import kvt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  int   fails;
  int   pending;
  int   replies;
  int   hits;
  int   fulls;
  int   words_sent;
  int   quiet_cycles;

  kvt_cmd_if cmd_ch ();
  kvt_rsp_if rsp_ch ();

  associative_key_value_table_core uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  kvt_checker scoreboard (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .fails   (fails),
    .pending (pending),
    .replies (replies),
    .hits    (hits),
    .fulls   (fulls)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Present one command word, maybe after an idle burst, and hold it until taken
  task automatic send_word(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.key     <= k;
    cmd_ch.value   <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    words_sent++;
  endtask

  // Drop valid and hold off until every outstanding response word is back;
  // first let the count update so it includes the word just taken
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Response side stalls in random bursts
  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct) begin
        rsp_ch.ready <= 1'b0;
        hold = $urandom_range(0, 16);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]   key_pool [64];
    int                 pool_n;
    int                 roll;
    logic [CMD_W-1:0]   op;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;

    rst            <= 1'b1;
    idle_pct       <= 0;
    words_sent     = 0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_SET;
    cmd_ch.key     <= '0;
    cmd_ch.value   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table, extremes, hit and miss on every command
    send_word(CMD_LOOKUP, '0, '1);
    send_word(CMD_SET, '0, '0);
    send_word(CMD_SET, '1, '1);
    send_word(CMD_SET, '0, '1);
    send_word(CMD_LOOKUP, '1, '0);
    send_word(CMD_ERASE, '0, '0);
    // erased entry still holds key zero but must not match
    send_word(CMD_LOOKUP, '0, '0);
    send_word(CMD_ERASE, '0, '1);
    send_word(CMD_UNUSED, '1, '1);
    // fill every free entry, then one more set that must be dropped
    for (int i = 1; i < ENTRIES; i++)
      send_word(CMD_SET, KEY_W'(i), $urandom);
    send_word(CMD_SET, 16'h1234, $urandom);

    // Random phases with different key pools and idle rates; last one runs flat out
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin idle_pct <= 30; pool_n = 20; end
        1: begin idle_pct <= 0;  pool_n = 8;  end
        2: begin idle_pct <= 10; pool_n = 24; end
        3: begin idle_pct <= 50; pool_n = 17; end
        4: begin idle_pct <= 20; pool_n = 64; end
        default: begin idle_pct <= 0; pool_n = 16; end
      endcase
      for (int i = 0; i < 64; i++)
        key_pool[i] = KEY_W'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) op = CMD_SET;
        else if (roll < 65) op = CMD_ERASE;
        else if (roll < 95) op = CMD_LOOKUP;
        else op = CMD_UNUSED;
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else k = KEY_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10) v = '0;
        else if (roll < 20) v = '1;
        else v = $urandom;
        send_word(op, k, v);
      end
    end

    // Drain, then give a stray extra response a chance to show up
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d command words and %0d response words,", words_sent, replies);
    $display("with %0d hits and %0d sets dropped on a full table", hits, fulls);
    if (pending != 0)
      $display("%0d response words never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fails);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kvt_pkg.sv
rtl/core/kvt_if.sv
rtl/core/kvt_cell.sv
rtl/core/associative_key_value_table_core.sv
bench/kvt_checker.sv
bench/testbench.sv
